// ----- design/round_robin_ready_queue_core_macros.svh -----
// Assertion macros for the round-robin ready queue core.
// Users must have clk_i and rst_ni in scope at the point of use.
`ifndef ROUND_ROBIN_READY_QUEUE_CORE_MACROS_SVH
`define ROUND_ROBIN_READY_QUEUE_CORE_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define RRQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define RRQ_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- design/rrq_pkg.sv -----
// Package for the round-robin ready queue: widths, codes and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package rrq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 6;
  localparam int TIME_W      = 8;
  localparam int ENTRY_W     = ID_W + TIME_W;
  localparam int WAIT_W      = 5;

  typedef enum logic {
    REQ_ARRIVAL = 1'b0,
    REQ_TICK    = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_QUEUED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_RAN     = 2'd2,
    ST_IDLE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_POP
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic arr_go;   // arrival transfer: push or drop, load result
    logic tick_go;  // tick transfer: requeue held entry
    logic rd_go;    // read queue head
    logic idle_go;  // load idle-tick result
    logic pop_go;   // consume head, load ran result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
    logic out_free;
  } dp_status_t;

endpackage

// ----- design/rrq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/rrq_ctrl.sv -----
// Sequencing FSM for the round-robin ready queue.
// Depends on rrq_pkg.
`timescale 1ns / 1ps

module rrq_ctrl import rrq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       req_type_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && status_i.out_free && (req_type_i == REQ_TICK)) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (!status_i.count_zero) begin
          state_d = S_POP;
        end else if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = status_i.out_free;
        cmd_o.arr_go  = in_valid_i && status_i.out_free && (req_type_i == REQ_ARRIVAL);
        cmd_o.tick_go = in_valid_i && status_i.out_free && (req_type_i == REQ_TICK);
      end
      S_READ: begin
        cmd_o.rd_go   = !status_i.count_zero;
        cmd_o.idle_go = status_i.count_zero && status_i.out_free;
      end
      S_POP: begin
        cmd_o.pop_go = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- design/rrq_dp.sv -----
// Datapath: queue pointers, count, held entry, ready store and result register.
// Depends on rrq_pkg and rrq_ram.
`timescale 1ns / 1ps

module rrq_dp import rrq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        status_o,
  input  logic [ID_W-1:0]   proc_id_i,
  input  logic [TIME_W-1:0] run_time_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_code_o,
  output logic [ID_W-1:0]   ran_id_o,
  output logic [TIME_W-1:0] remaining_o,
  output logic              finished_o,
  output logic [WAIT_W-1:0] waiting_o
);

  localparam logic [PTR_W-1:0] PtrLast = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W:0]   DepthW  = (CNT_W + 1)'(QUEUE_DEPTH);

  logic [PTR_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ID_W-1:0]   held_id_q, held_id_d;
  logic [TIME_W-1:0] held_time_q, held_time_d;
  logic              held_valid_q, held_valid_d;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        st_q, st_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [TIME_W-1:0] rem_q, rem_d;
  logic              fin_q, fin_d;
  logic [WAIT_W-1:0] wait_q, wait_d;

  logic               we;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;
  logic [CNT_W:0]     occupancy;
  logic               full;
  logic [ID_W-1:0]    pop_id;
  logic [TIME_W-1:0]  pop_time, pop_rem;
  logic               pop_fin;
  logic               out_free;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  assign occupancy = {1'b0, count_q} + (CNT_W + 1)'(held_valid_q);
  assign full      = (occupancy >= DepthW);
  assign out_free  = !out_valid_q || out_ready_i;

  assign pop_id   = rdata[ENTRY_W-1:TIME_W];
  assign pop_time = rdata[TIME_W-1:0];
  assign pop_rem  = (pop_time == '0) ? '0 : pop_time - 1'b1;
  assign pop_fin  = (pop_rem == '0);

  rrq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tail_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_go),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  always_comb begin
    we           = 1'b0;
    wdata        = {proc_id_i, run_time_i};
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    held_id_d    = held_id_q;
    held_time_d  = held_time_q;
    held_valid_d = held_valid_q;
    st_d         = st_q;
    id_d         = id_q;
    rem_d        = rem_q;
    fin_d        = fin_q;
    wait_d       = wait_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    if (cmd_i.arr_go) begin
      out_valid_d = 1'b1;
      id_d        = '0;
      rem_d       = '0;
      fin_d       = 1'b0;
      if (full) begin
        st_d   = ST_DROPPED;
        wait_d = WAIT_W'(occupancy);
      end else begin
        we      = 1'b1;
        tail_d  = ptr_inc(tail_q);
        count_d = count_q + 1'b1;
        st_d    = ST_QUEUED;
        wait_d  = WAIT_W'(occupancy + 1'b1);
      end
    end

    if (cmd_i.tick_go) begin
      // preempted process goes behind this tick's arrivals
      if (held_valid_q && (count_q < CNT_W'(QUEUE_DEPTH))) begin
        we      = 1'b1;
        wdata   = {held_id_q, held_time_q};
        tail_d  = ptr_inc(tail_q);
        count_d = count_q + 1'b1;
      end
      held_valid_d = 1'b0;
      held_id_d    = '0;
      held_time_d  = '0;
    end

    if (cmd_i.idle_go) begin
      out_valid_d = 1'b1;
      st_d        = ST_IDLE;
      id_d        = '0;
      rem_d       = '0;
      fin_d       = 1'b0;
      wait_d      = WAIT_W'(count_q);
    end

    if (cmd_i.pop_go) begin
      out_valid_d  = 1'b1;
      head_d       = ptr_inc(head_q);
      count_d      = count_q - 1'b1;
      st_d         = ST_RAN;
      id_d         = pop_id;
      rem_d        = pop_rem;
      fin_d        = pop_fin;
      held_valid_d = !pop_fin;
      held_id_d    = pop_fin ? '0 : pop_id;
      held_time_d  = pop_rem;
      wait_d       = WAIT_W'({1'b0, count_q} - 1'b1 + (CNT_W + 1)'(!pop_fin));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      held_id_q    <= '0;
      held_time_q  <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      held_id_q    <= held_id_d;
      held_time_q  <= held_time_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q   <= st_d;
    id_q   <= id_d;
    rem_q  <= rem_d;
    fin_q  <= fin_d;
    wait_q <= wait_d;
  end

  assign status_o.count_zero = (count_q == '0);
  assign status_o.out_free   = out_free;

  assign out_valid_o   = out_valid_q;
  assign status_code_o = st_q;
  assign ran_id_o      = id_q;
  assign remaining_o   = rem_q;
  assign finished_o    = fin_q;
  assign waiting_o     = wait_q;

endmodule

// ----- design/round_robin_ready_queue_core.sv -----
// Round-robin ready queue core, one-tick quantum. Arrival: the result register is
// loaded from the transfer; next item accepted the following cycle. Tick: requeue
// held entry, read queue head from the ready store RAM, decrement and load result;
// an empty queue gets an idle result. No new request until a tick's result is in.
// A stalled result register holds off input. Reset (rst_ni, async active low)
// empties queue and held entry; no clearing pass, store only read once written.
`timescale 1ns / 1ps
`include "round_robin_ready_queue_core_macros.svh"

module round_robin_ready_queue_core import rrq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [ID_W-1:0]   proc_id_i,
  input  logic [TIME_W-1:0] run_time_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [ID_W-1:0]   ran_id_o,
  output logic [TIME_W-1:0] remaining_o,
  output logic              finished_o,
  output logic [WAIT_W-1:0] waiting_o
);

  // Controller issues one-hot-per-cycle commands; datapath reports whether
  // the queue is empty and whether the result register can take a new result.
  dp_cmd_t    cmd;
  dp_status_t dp_status;

  rrq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  // Datapath holds the ready store, head/tail pointers, entry count, the
  // preempted (held) entry and the output register, which decouples a
  // stalled consumer from the next input transfer.
  rrq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (dp_status),
    .proc_id_i     (proc_id_i),
    .run_time_i    (run_time_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_code_o (status_o),
    .ran_id_o      (ran_id_o),
    .remaining_o   (remaining_o),
    .finished_o    (finished_o),
    .waiting_o     (waiting_o)
  );

  // Occupancy never exceeds the queue depth.
  `RRQ_ASSERT(a_wait_bound, !out_valid_o || (waiting_o <= WAIT_W'(QUEUE_DEPTH)), "waiting over depth")
  // A process that finished has no service left.
  `RRQ_ASSERT(a_fin_rem, !(out_valid_o && finished_o) || (remaining_o == '0), "finished with time left")
  // A tick transfer keeps the input closed while the head is fetched.
  `RRQ_ASSERT_NEXT(a_tick_busy, in_valid_i && in_ready_o && (req_type_i == REQ_TICK), !in_ready_o, "tick overlap")

endmodule
